### src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shorthands for clocked, reset-qualified concurrent assertions.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication on aclk, off while aresetn is low.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication on aclk, off while aresetn is low.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

### src/ptts_pkg.sv
// ---------------------------------------------------------------------------
// ptts_pkg
// Types, codes and fixed-point helpers for the pan/tilt sweep controller.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptts_pkg;

    // Input command codes
    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_REPORT = 2'd1;
    localparam logic [1:0] CMD_IDLE   = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_PAN_STEP      = 3'd0;
    localparam logic [2:0] REG_TILT_STEP     = 3'd1;
    localparam logic [2:0] REG_PAN_INTERVAL  = 3'd2;
    localparam logic [2:0] REG_TILT_INTERVAL = 3'd3;
    localparam logic [2:0] REG_TRACK_TIMEOUT = 3'd4;
    localparam logic [2:0] REG_PAN_LIMIT     = 3'd5;

    localparam logic [11:0] ANGLE_MAX      = 12'd4095;
    localparam logic [11:0] TILT_START     = 12'd1100;
    localparam logic [11:0] TILT_GOAL_INIT = 12'd1200;
    localparam logic [9:0]  UPD_SAT        = 10'd1023;

    // Result queue between the update stage and the output register
    localparam int RQ_DEPTH = 4;
    localparam int RQ_PTR_W = 2;
    localparam int RQ_CNT_W = 3;

    localparam int DEG_W = 9;

    typedef struct packed {
        logic             sel;
        logic [DEG_W-1:0] deg;
        logic             last;
    } res_t;

    // Tilt pattern 110,115,120,115 repeating, in tenths
    function automatic logic [11:0] tilt_goal_of(input logic [3:0] idx);
        logic [11:0] g;
        case (idx[1:0])
            2'd0:    g = 12'd1100;
            2'd1:    g = 12'd1150;
            2'd2:    g = 12'd1200;
            default: g = 12'd1150;
        endcase
        return g;
    endfunction

    // floor(a/10) for a < 4096: a*6554 >> 16 is exact over this range
    function automatic logic [DEG_W-1:0] tenths_to_deg(input logic [11:0] a);
        logic [24:0] prod;
        prod = {13'd0, a} * 25'd6554;
        return prod[24:16];
    endfunction

    // floor(deg*4095/240) = floor(deg*273/16), saturated at 4095
    function automatic logic [11:0] deg_to_pos(input logic [DEG_W-1:0] d);
        logic [16:0] prod;
        prod = {8'd0, d} * 17'd273;
        return prod[16] ? 12'd4095 : prod[15:4];
    endfunction

    // Step an angle toward a goal; equal moves down; clamps at 0 and 4095
    function automatic logic [11:0] move_toward(input logic [11:0] a,
                                                input logic [11:0] goal,
                                                input logic [5:0]  step);
        logic [12:0] sum;
        logic [11:0] r;
        sum = {1'b0, a} + {7'd0, step};
        if (a < goal) begin
            r = sum[12] ? ANGLE_MAX : sum[11:0];
        end else begin
            r = (a > {6'd0, step}) ? (a - {6'd0, step}) : 12'd0;
        end
        return r;
    endfunction

    function automatic logic [11:0] abs_diff(input logic [11:0] a,
                                             input logic [11:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

endpackage

### src/pan_tilt_track_sweep_controller.sv
// ---------------------------------------------------------------------------
// pan_tilt_track_sweep_controller
// An item is registered on acceptance, processed from the input register
// (state update plus degree conversion) into a four-entry result queue once
// the queue has room, and each result is scaled to servo units on its way
// into the output register. A new item is taken every cycle as long as the
// queue has room for two results; the output side drains one result per
// cycle while m_ready is high, so a position report (two results) or a tick
// that moves both servos fills the queue faster than it drains; other items
// keep one per cycle. Configuration writes take effect for the next item.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pan_tilt_track_sweep_controller #(
    parameter int PATTERN_LENGTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [9:0]  s_target_x,
    input  logic [8:0]  s_target_y,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_servo_select,
    output logic [11:0] m_servo_position,
    output logic        m_last
);

    localparam int PIDX_W = (PATTERN_LENGTH > 1) ? $clog2(PATTERN_LENGTH) : 1;
    localparam logic [PIDX_W-1:0] PIDX_LAST = PIDX_W'(PATTERN_LENGTH - 1);
    localparam logic [ptts_pkg::RQ_CNT_W-1:0] RQ_FULL =
        ptts_pkg::RQ_CNT_W'(ptts_pkg::RQ_DEPTH);

    // Configuration
    logic [5:0]  pan_step_reg, tilt_step_reg;
    logic [9:0]  pan_interval_reg, tilt_interval_reg;
    logic [15:0] track_timeout_reg;
    logic [11:0] pan_limit_reg;

    // Controller state
    logic [11:0]       pan_angle_reg, pan_angle_next;
    logic              heading_max_reg, heading_max_next;
    logic [11:0]       tilt_angle_reg, tilt_angle_next;
    logic [11:0]       tilt_goal_reg, tilt_goal_next;
    logic [PIDX_W-1:0] pidx_reg, pidx_next;
    logic              tracking_reg, tracking_next;
    logic [15:0]       since_report_reg, since_report_next;
    logic [9:0]        since_pan_reg, since_pan_next;
    logic [9:0]        since_tilt_reg, since_tilt_next;

    // Input stage
    logic       in_valid_reg;
    logic [1:0] in_cmd_reg;
    logic [9:0] in_x_reg;
    logic [8:0] in_y_reg;

    // Result queue
    ptts_pkg::res_t                rq_mem [ptts_pkg::RQ_DEPTH];
    logic [ptts_pkg::RQ_PTR_W-1:0] rq_wr_reg, rq_rd_reg;
    logic [ptts_pkg::RQ_CNT_W-1:0] rq_cnt_reg;

    // Output register
    logic        m_valid_reg;
    logic        m_sel_reg;
    logic [11:0] m_pos_reg;
    logic        m_last_reg;

    logic           proc_fire;
    logic           out_load;
    logic [1:0]     n_push;
    ptts_pkg::res_t e0, e1;

    // Working signals for the update
    logic [13:0] x_mul;
    logic [18:0] y_mul;
    logic [15:0] sr_inc;
    logic [9:0]  pu_inc, tu_inc;
    logic        sweep, pan_do, tilt_do;
    logic        head_flip;
    logic [11:0] pan_target;
    logic [PIDX_W-1:0] pidx_adv;

    // Checker views
    logic                          report_fire, idle_fire;
    logic                          tracking_armed;
    logic [ptts_pkg::RQ_CNT_W-1:0] rq_cnt_pop, rq_cnt_rpt;

    assign cfg_ready = 1'b1;
    assign proc_fire = in_valid_reg && (rq_cnt_reg <= ptts_pkg::RQ_CNT_W'(2));
    assign s_ready   = !in_valid_reg || proc_fire;
    assign out_load  = (rq_cnt_reg != '0) && (!m_valid_reg || m_ready);

    assign x_mul = {4'd0, in_x_reg} * 14'd9;      // x*45/640 == x*9/128
    assign y_mul = {10'd0, in_y_reg} * 19'd683;   // y/48 via 683/2^15

    always_comb begin
        pan_angle_next    = pan_angle_reg;
        heading_max_next  = heading_max_reg;
        tilt_angle_next   = tilt_angle_reg;
        tilt_goal_next    = tilt_goal_reg;
        pidx_next         = pidx_reg;
        tracking_next     = tracking_reg;
        since_report_next = since_report_reg;
        since_pan_next    = since_pan_reg;
        since_tilt_next   = since_tilt_reg;
        n_push            = 2'd0;
        e0                = '0;
        e1                = '0;

        sr_inc = (&since_report_reg) ? since_report_reg : since_report_reg + 16'd1;
        pu_inc = (&since_pan_reg)    ? since_pan_reg    : since_pan_reg + 10'd1;
        tu_inc = (&since_tilt_reg)   ? since_tilt_reg   : since_tilt_reg + 10'd1;
        sweep   = !(tracking_reg && (sr_inc <= track_timeout_reg));
        pan_do  = sweep && (pu_inc >= pan_interval_reg);
        tilt_do = sweep && (tu_inc >= tilt_interval_reg);

        pan_target = heading_max_reg ? pan_limit_reg : 12'd0;
        head_flip  = ptts_pkg::abs_diff(pan_angle_reg, pan_target) < 12'd5;
        if (head_flip) begin
            pan_target = heading_max_reg ? 12'd0 : pan_limit_reg;
        end
        pidx_adv = (pidx_reg == PIDX_LAST) ? '0 : pidx_reg + PIDX_W'(1);

        if (proc_fire) begin
            case (in_cmd_reg)
                ptts_pkg::CMD_REPORT: begin
                    tracking_next     = 1'b1;
                    since_report_next = 16'd0;
                    n_push            = 2'd2;
                    e0.sel  = 1'b0;
                    e0.deg  = {2'd0, x_mul[13:7]};
                    e0.last = 1'b0;
                    e1.sel  = 1'b1;
                    e1.deg  = 9'd110 + {5'd0, y_mul[18:15]};
                    e1.last = 1'b1;
                end
                ptts_pkg::CMD_IDLE: begin
                    tracking_next = 1'b0;
                end
                ptts_pkg::CMD_TICK: begin
                    since_report_next = sr_inc;
                    since_pan_next    = pu_inc;
                    since_tilt_next   = tu_inc;
                    if (sweep) begin
                        tracking_next = 1'b0;
                    end
                    if (pan_do) begin
                        since_pan_next   = 10'd0;
                        heading_max_next = heading_max_reg ^ head_flip;
                        pan_angle_next   = ptts_pkg::move_toward(pan_angle_reg, pan_target,
                                                                 pan_step_reg);
                    end
                    if (tilt_do) begin
                        since_tilt_next = 10'd0;
                        if (ptts_pkg::abs_diff(tilt_angle_reg, tilt_goal_reg) < 12'd3) begin
                            pidx_next      = pidx_adv;
                            tilt_goal_next = ptts_pkg::tilt_goal_of(4'(pidx_adv));
                        end
                        tilt_angle_next = ptts_pkg::move_toward(tilt_angle_reg,
                                                                tilt_goal_next, tilt_step_reg);
                    end
                    n_push = {1'b0, pan_do} + {1'b0, tilt_do};
                    // pan first when both move; the later one carries last
                    e1.sel  = 1'b1;
                    e1.deg  = ptts_pkg::tenths_to_deg(tilt_angle_next);
                    e1.last = 1'b1;
                    if (pan_do) begin
                        e0.sel  = 1'b0;
                        e0.deg  = ptts_pkg::tenths_to_deg(pan_angle_next);
                        e0.last = !tilt_do;
                    end else begin
                        e0 = e1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Configuration and controller state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pan_step_reg      <= 6'd2;
            tilt_step_reg     <= 6'd1;
            pan_interval_reg  <= 10'd40;
            tilt_interval_reg <= 10'd30;
            track_timeout_reg <= 16'd1000;
            pan_limit_reg     <= 12'd450;
            pan_angle_reg     <= 12'd0;
            heading_max_reg   <= 1'b1;
            tilt_angle_reg    <= ptts_pkg::TILT_START;
            tilt_goal_reg     <= ptts_pkg::TILT_GOAL_INIT;
            pidx_reg          <= '0;
            tracking_reg      <= 1'b0;
            since_report_reg  <= 16'd0;
            since_pan_reg     <= ptts_pkg::UPD_SAT;
            since_tilt_reg    <= ptts_pkg::UPD_SAT;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    ptts_pkg::REG_PAN_STEP:      pan_step_reg      <= cfg_data[5:0];
                    ptts_pkg::REG_TILT_STEP:     tilt_step_reg     <= cfg_data[5:0];
                    ptts_pkg::REG_PAN_INTERVAL:  pan_interval_reg  <= cfg_data[9:0];
                    ptts_pkg::REG_TILT_INTERVAL: tilt_interval_reg <= cfg_data[9:0];
                    ptts_pkg::REG_TRACK_TIMEOUT: track_timeout_reg <= cfg_data;
                    ptts_pkg::REG_PAN_LIMIT:     pan_limit_reg     <= cfg_data[11:0];
                    default: begin
                    end
                endcase
            end
            pan_angle_reg    <= pan_angle_next;
            heading_max_reg  <= heading_max_next;
            tilt_angle_reg   <= tilt_angle_next;
            tilt_goal_reg    <= tilt_goal_next;
            pidx_reg         <= pidx_next;
            tracking_reg     <= tracking_next;
            since_report_reg <= since_report_next;
            since_pan_reg    <= since_pan_next;
            since_tilt_reg   <= since_tilt_next;
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_cmd_reg <= s_command;
            in_x_reg   <= s_target_x;
            in_y_reg   <= s_target_y;
        end
    end

    // Result queue
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rq_wr_reg  <= '0;
            rq_rd_reg  <= '0;
            rq_cnt_reg <= '0;
        end else begin
            rq_wr_reg  <= rq_wr_reg + ptts_pkg::RQ_PTR_W'(n_push);
            rq_rd_reg  <= rq_rd_reg + ptts_pkg::RQ_PTR_W'(out_load);
            rq_cnt_reg <= rq_cnt_reg + ptts_pkg::RQ_CNT_W'(n_push)
                        - ptts_pkg::RQ_CNT_W'(out_load);
        end
    end

    always_ff @(posedge aclk) begin
        if (n_push != 2'd0) begin
            rq_mem[rq_wr_reg] <= e0;
        end
        if (n_push == 2'd2) begin
            rq_mem[rq_wr_reg + ptts_pkg::RQ_PTR_W'(1)] <= e1;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_ready) begin
            m_valid_reg <= (rq_cnt_reg != '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_sel_reg  <= rq_mem[rq_rd_reg].sel;
            m_pos_reg  <= ptts_pkg::deg_to_pos(rq_mem[rq_rd_reg].deg);
            m_last_reg <= rq_mem[rq_rd_reg].last;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_servo_select   = m_sel_reg;
    assign m_servo_position = m_pos_reg;
    assign m_last           = m_last_reg;

    assign report_fire    = proc_fire && (in_cmd_reg == ptts_pkg::CMD_REPORT);
    assign idle_fire      = proc_fire && (in_cmd_reg == ptts_pkg::CMD_IDLE);
    assign tracking_armed = tracking_reg && (since_report_reg == 16'd0);
    assign rq_cnt_pop     = rq_cnt_reg - ptts_pkg::RQ_CNT_W'(out_load);
    assign rq_cnt_rpt     = rq_cnt_pop + ptts_pkg::RQ_CNT_W'(2);

`include "assert_macros.svh"

    `ASSERT_SAME(a_rq_bound, 1'b1, rq_cnt_reg <= RQ_FULL, "result queue overflow")
    `ASSERT_NEXT(a_report_push, report_fire, rq_cnt_reg == $past(rq_cnt_rpt), "report count off")
    `ASSERT_NEXT(a_report_arms, report_fire, tracking_armed, "report did not arm tracking")
    `ASSERT_NEXT(a_idle_disarms, idle_fire, !tracking_reg, "idle left tracking on")
    `ASSERT_NEXT(a_idle_quiet, idle_fire, rq_cnt_reg == $past(rq_cnt_pop), "idle queued a result")

endmodule
